/* design/shs_pkg.sv */
`default_nettype none

package shs_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned WINDOW_LEN = 16;
    localparam int unsigned ROUNDS     = 64;
    localparam int unsigned DIGEST_LEN = 8;
    localparam int unsigned POS_W      = $clog2(WINDOW_LEN);
    localparam int unsigned ROUND_W    = $clog2(ROUNDS);
    localparam int unsigned IDX_W      = $clog2(DIGEST_LEN);
    localparam int unsigned NBYTES_W   = 3;
    localparam int unsigned LEN_W      = 64;

    localparam logic [WORD_W-1:0]   PAD_MARK_WORD = 32'h8000_0000;
    localparam logic [7:0]          PAD_BYTE      = 8'h80;
    localparam logic [NBYTES_W-1:0] FULL_BYTES    = 3'd4;
    localparam logic [POS_W-1:0]    POS_LEN_HI    = 4'd14;
    localparam logic [POS_W-1:0]    POS_LAST      = 4'd15;
    localparam logic [ROUND_W-1:0]  ROUND_LAST    = 6'd63;
    localparam logic [IDX_W-1:0]    IDX_LAST      = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN_HI,
        PAD_LEN_LO
    } t_pad_sel;

    typedef struct packed {
        logic                accept;
        logic                push_pad;
        t_pad_sel            pad_sel;
        logic                init_vars;
        logic                round;
        logic [ROUND_W-1:0]  round_idx;
        logic                fold;
        logic [IDX_W-1:0]    digest_idx;
        logic                restart;
    } t_cmd;

    typedef struct packed {
        logic [POS_W-1:0] pos;
    } t_stat;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] init_hash(input logic [IDX_W-1:0] idx);
        logic [WORD_W-1:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] round_const(input logic [ROUND_W-1:0] t);
        logic [WORD_W-1:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

/* design/shs_ctrl.sv */
`default_nettype none

module shs_ctrl (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    input  wire                                  i_last,
    input  wire  [shs_pkg::NBYTES_W-1:0]         i_valid_bytes,
    output logic                                 o_ready,
    output logic                                 o_valid,
    output logic                                 o_digest_last,
    input  wire                                  i_ready,
    input  shs_pkg::t_stat                       i_stat,
    output shs_pkg::t_cmd                        o_cmd
);

    shs_pkg::t_state                 r_state, n_state;
    logic [shs_pkg::ROUND_W-1:0]     r_cnt, n_cnt;
    logic [shs_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic                            r_padding, n_padding;
    logic                            r_need_mark, n_need_mark;
    logic                            r_hi_done, n_hi_done;
    logic                            r_finish, n_finish;
    logic                            w_wrap;

    assign w_wrap = (i_stat.pos == shs_pkg::POS_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= shs_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_padding   <= 1'b0;
            r_need_mark <= 1'b0;
            r_hi_done   <= 1'b0;
            r_finish    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_padding   <= n_padding;
            r_need_mark <= n_need_mark;
            r_hi_done   <= n_hi_done;
            r_finish    <= n_finish;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_padding   = r_padding;
        n_need_mark = r_need_mark;
        n_hi_done   = r_hi_done;
        n_finish    = r_finish;
        o_ready       = 1'b0;
        o_valid       = 1'b0;
        o_digest_last = (r_idx == shs_pkg::IDX_LAST);
        o_cmd            = '0;
        o_cmd.pad_sel    = shs_pkg::PAD_ZERO;
        o_cmd.round_idx  = r_cnt;
        o_cmd.digest_idx = r_idx;

        case (r_state)
            shs_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_last) begin
                        // A full final word leaves the marker byte for the next word.
                        n_padding   = 1'b1;
                        n_need_mark = (i_valid_bytes >= shs_pkg::FULL_BYTES);
                        n_hi_done   = 1'b0;
                        n_finish    = 1'b0;
                        n_state     = shs_pkg::ST_PAD;
                    end
                    if (w_wrap) begin
                        o_cmd.init_vars = 1'b1;
                        n_cnt           = '0;
                        n_state         = shs_pkg::ST_ROUND;
                    end
                end
            end

            shs_pkg::ST_PAD: begin
                o_cmd.push_pad = 1'b1;
                if (r_need_mark) begin
                    o_cmd.pad_sel = shs_pkg::PAD_MARK;
                    n_need_mark   = 1'b0;
                end else if (i_stat.pos == shs_pkg::POS_LEN_HI) begin
                    o_cmd.pad_sel = shs_pkg::PAD_LEN_HI;
                    n_hi_done     = 1'b1;
                end else if (w_wrap && r_hi_done) begin
                    o_cmd.pad_sel = shs_pkg::PAD_LEN_LO;
                    n_finish      = 1'b1;
                end
                if (w_wrap) begin
                    o_cmd.init_vars = 1'b1;
                    n_cnt           = '0;
                    n_state         = shs_pkg::ST_ROUND;
                end
            end

            shs_pkg::ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == shs_pkg::ROUND_LAST) begin
                    n_state = shs_pkg::ST_FOLD;
                end
            end

            shs_pkg::ST_FOLD: begin
                o_cmd.fold = 1'b1;
                if (r_finish) begin
                    n_idx   = '0;
                    n_state = shs_pkg::ST_OUT;
                end else if (r_padding) begin
                    n_state = shs_pkg::ST_PAD;
                end else begin
                    n_state = shs_pkg::ST_IDLE;
                end
            end

            shs_pkg::ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == shs_pkg::IDX_LAST) begin
                        o_cmd.restart = 1'b1;
                        n_padding     = 1'b0;
                        n_finish      = 1'b0;
                        n_idx         = '0;
                        n_state       = shs_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = shs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/shs_datapath.sv */
`default_nettype none

module shs_datapath (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire  [shs_pkg::WORD_W-1:0]           i_msg_word,
    input  wire  [shs_pkg::NBYTES_W-1:0]         i_valid_bytes,
    input  wire                                  i_last,
    input  shs_pkg::t_cmd                        i_cmd,
    output shs_pkg::t_stat                       o_stat,
    output logic [shs_pkg::WORD_W-1:0]           o_digest_word
);

    logic [shs_pkg::WORD_W-1:0]  r_chain [shs_pkg::DIGEST_LEN];
    logic [shs_pkg::WORD_W-1:0]  r_var   [shs_pkg::DIGEST_LEN];
    logic [shs_pkg::WORD_W-1:0]  r_win   [shs_pkg::WINDOW_LEN];
    logic [shs_pkg::POS_W-1:0]   r_pos;
    logic [shs_pkg::LEN_W-1:0]   r_bitlen;

    logic [shs_pkg::WORD_W-1:0]  w_first;
    logic [shs_pkg::WORD_W-1:0]  w_pad;
    logic [shs_pkg::WORD_W-1:0]  w_push_word;
    logic                        w_push;
    logic [5:0]                  w_add_bits;
    logic [shs_pkg::WORD_W-1:0]  w_next_sched;
    logic [shs_pkg::WORD_W-1:0]  w_t1;
    logic [shs_pkg::WORD_W-1:0]  w_t2;
    logic [shs_pkg::WORD_W-1:0]  w_sig0;
    logic [shs_pkg::WORD_W-1:0]  w_sig1;

    // First word of the final beat: for a partial word, clear stray bytes and place the marker byte.
    always_comb begin
        w_first    = i_msg_word;
        w_add_bits = 6'd32;
        if (i_last) begin
            case (i_valid_bytes)
                3'd0: begin
                    w_first    = {shs_pkg::PAD_BYTE, 24'h0};
                    w_add_bits = 6'd0;
                end
                3'd1: begin
                    w_first    = {i_msg_word[31:24], shs_pkg::PAD_BYTE, 16'h0};
                    w_add_bits = 6'd8;
                end
                3'd2: begin
                    w_first    = {i_msg_word[31:16], shs_pkg::PAD_BYTE, 8'h0};
                    w_add_bits = 6'd16;
                end
                3'd3: begin
                    w_first    = {i_msg_word[31:8], shs_pkg::PAD_BYTE};
                    w_add_bits = 6'd24;
                end
                default: begin
                    w_first    = i_msg_word;
                    w_add_bits = 6'd32;
                end
            endcase
        end
    end

    always_comb begin
        case (i_cmd.pad_sel)
            shs_pkg::PAD_MARK:   w_pad = shs_pkg::PAD_MARK_WORD;
            shs_pkg::PAD_LEN_HI: w_pad = r_bitlen[63:32];
            shs_pkg::PAD_LEN_LO: w_pad = r_bitlen[31:0];
            default:             w_pad = '0;
        endcase
    end

    assign w_push      = i_cmd.accept | i_cmd.push_pad;
    assign w_push_word = i_cmd.accept ? w_first : w_pad;

    // The window holds W[t..t+15] during round t; slot 15 takes W[t+16].
    assign w_sig0 = shs_pkg::rotr(r_win[1], 7) ^ shs_pkg::rotr(r_win[1], 18)
                  ^ (r_win[1] >> 3);
    assign w_sig1 = shs_pkg::rotr(r_win[14], 17) ^ shs_pkg::rotr(r_win[14], 19)
                  ^ (r_win[14] >> 10);
    assign w_next_sched = w_sig1 + r_win[9] + w_sig0 + r_win[0];

    assign w_t1 = r_var[7]
                + (shs_pkg::rotr(r_var[4], 6) ^ shs_pkg::rotr(r_var[4], 11)
                   ^ shs_pkg::rotr(r_var[4], 25))
                + ((r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]))
                + shs_pkg::round_const(i_cmd.round_idx) + r_win[0];
    assign w_t2 = (shs_pkg::rotr(r_var[0], 2) ^ shs_pkg::rotr(r_var[0], 13)
                   ^ shs_pkg::rotr(r_var[0], 22))
                + ((r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]));

    always_ff @(posedge i_clk) begin
        if (w_push || i_cmd.round) begin
            for (int i = 0; i < shs_pkg::WINDOW_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[shs_pkg::WINDOW_LEN-1] <= w_push ? w_push_word : w_next_sched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_vars) begin
            for (int i = 0; i < shs_pkg::DIGEST_LEN; i++) begin
                r_var[i] <= r_chain[i];
            end
        end else if (i_cmd.round) begin
            r_var[7] <= r_var[6];
            r_var[6] <= r_var[5];
            r_var[5] <= r_var[4];
            r_var[4] <= r_var[3] + w_t1;
            r_var[3] <= r_var[2];
            r_var[2] <= r_var[1];
            r_var[1] <= r_var[0];
            r_var[0] <= w_t1 + w_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            for (int i = 0; i < shs_pkg::DIGEST_LEN; i++) begin
                r_chain[i] <= shs_pkg::init_hash(shs_pkg::IDX_W'(i));
            end
            r_pos    <= '0;
            r_bitlen <= '0;
        end else begin
            if (i_cmd.fold) begin
                for (int i = 0; i < shs_pkg::DIGEST_LEN; i++) begin
                    r_chain[i] <= r_chain[i] + r_var[i];
                end
            end
            if (w_push) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.accept) begin
                r_bitlen <= r_bitlen + {{(shs_pkg::LEN_W-6){1'b0}}, w_add_bits};
            end
        end
    end

    assign o_stat.pos    = r_pos;
    assign o_digest_word = r_chain[i_cmd.digest_idx];

endmodule

`default_nettype wire

/* design/sha256_stream_hasher_core.sv */
`default_nettype none

// Channel   Direction  Handshake           Payload
// message   in         i_valid / o_ready   i_msg_word, i_valid_bytes, i_last
// digest    out        o_valid / i_ready   o_digest_word, o_digest_last
//
// A message beat is taken when i_valid and o_ready are both high. The sixteenth beat of a
// block starts the compression: 64 rounds, one per cycle, and then a fold into the chaining
// value. The final beat adds one padding word per cycle, plus a compression for each block
// it closes, then eight digest beats; o_ready is low from the final beat until the eighth
// digest beat is taken. Reset is synchronous and returns the initial hash.
module sha256_stream_hasher_core (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire  [shs_pkg::WORD_W-1:0]           i_msg_word,
    input  wire  [shs_pkg::NBYTES_W-1:0]         i_valid_bytes,
    input  wire                                  i_last,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic [shs_pkg::WORD_W-1:0]           o_digest_word,
    output logic                                 o_digest_last
);

    shs_pkg::t_cmd  w_cmd;
    shs_pkg::t_stat w_stat;

    shs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_last        (i_last),
        .i_valid_bytes (i_valid_bytes),
        .o_ready       (o_ready),
        .o_valid       (o_valid),
        .o_digest_last (o_digest_last),
        .i_ready       (i_ready),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd)
    );

    shs_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_msg_word    (i_msg_word),
        .i_valid_bytes (i_valid_bytes),
        .i_last        (i_last),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_digest_word (o_digest_word)
    );

endmodule

`default_nettype wire

/* sim/sha256_stream_hasher_core_tb.sv */
`timescale 1ns / 1ps

module sha256_stream_hasher_core_tb;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_BEATS = 210;
    localparam int unsigned MAX_GAP      = 17;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned DIGEST_WORDS = 8;
    localparam int unsigned SETTLE_TIME  = 200;

    localparam logic [shs_pkg::NBYTES_W-1:0] WHOLE_WORD = 3'd4;
    localparam logic [3:0]          LEN_SLOT   = 4'd14;
    localparam logic [31:0]         MARK_WORD  = 32'h8000_0000;
    localparam logic [31:0]         MARK_BYTE  = 32'h0000_0080;

    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [64*32-1:0] SHA_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct {
        logic [shs_pkg::WORD_W-1:0]   word;
        logic [shs_pkg::NBYTES_W-1:0] nbytes;
        logic                         last;
        int unsigned                  gap;
        bit                           hold;
    } t_msg_beat;

    typedef struct {
        logic [shs_pkg::WORD_W-1:0] word;
        logic                       last;
    } t_digest_beat;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic [shs_pkg::WORD_W-1:0]   i_msg_word = '0;
    logic [shs_pkg::NBYTES_W-1:0] i_valid_bytes = '0;
    logic                         i_last = 1'b0;
    logic                         i_ready = 1'b0;
    logic                         o_ready;
    logic                         o_valid;
    logic [shs_pkg::WORD_W-1:0]   o_digest_word;
    logic                         o_digest_last;

    t_msg_beat    msg_beats_q[$];
    t_digest_beat digests_q[$];

    // Predicted hash state.
    logic [31:0] hash_st [8];
    logic [31:0] sched [16];
    logic [3:0]  sched_pos;
    logic [63:0] msg_bits;

    t_msg_beat   cur_beat;
    bit          staged = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    bit          msg_taken = 1'b0;
    bit          dig_taken = 1'b0;
    bit          dig_offered = 1'b0;
    int unsigned beats_loaded = 0;
    int unsigned beats_accepted = 0;
    int unsigned errors = 0;

    sha256_stream_hasher_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_msg_word    (i_msg_word),
        .i_valid_bytes (i_valid_bytes),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digest_word (o_digest_word),
        .o_digest_last (o_digest_last)
    );

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    task automatic reset_hash();
        for (int j = 0; j < 8; j++) begin
            hash_st[j] = SHA_IV[(7 - j) * 32 +: 32];
        end
        sched_pos = '0;
        msg_bits  = '0;
    endtask

    task automatic sha_compress();
        logic [31:0] v [8];
        logic [31:0] x15, x2, t1, t2;
        for (int j = 0; j < 8; j++) begin
            v[j] = hash_st[j];
        end
        for (int t = 0; t < 64; t++) begin
            // The window is rolled in place: slot t%16 becomes w[t] once t reaches 16.
            if (t >= 16) begin
                x15 = sched[(t + 1) % 16];
                x2  = sched[(t + 14) % 16];
                sched[t % 16] = sched[t % 16] + sched[(t + 9) % 16]
                    + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3))
                    + (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10));
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[(63 - t) * 32 +: 32]
               + sched[t % 16];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) begin
            hash_st[j] = hash_st[j] + v[j];
        end
    endtask

    task automatic push_sched(input logic [31:0] w);
        sched[sched_pos] = w;
        sched_pos = sched_pos + 4'd1;
        if (sched_pos == 4'd0) begin
            sha_compress();
        end
    endtask

    task automatic hash_beat(input logic [shs_pkg::WORD_W-1:0] word,
                             input logic [shs_pkg::NBYTES_W-1:0] nb,
                             input logic last);
        logic [shs_pkg::NBYTES_W-1:0] n;
        logic [31:0]                  keep;
        t_digest_beat                 d;
        if (!last) begin
            push_sched(word);
            msg_bits = msg_bits + 64'd32;
        end else begin
            n = (nb > WHOLE_WORD) ? WHOLE_WORD : nb;
            msg_bits = msg_bits + (64'(n) << 3);
            if (n == WHOLE_WORD) begin
                push_sched(word);
                push_sched(MARK_WORD);
            end else begin
                // Bytes beyond the count are dropped before the marker byte goes in.
                keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (8 * (4 - n)));
                push_sched((word & keep) | (MARK_BYTE << (8 * (3 - n))));
            end
            while (sched_pos != LEN_SLOT) begin
                push_sched(32'h0);
            end
            push_sched(msg_bits[63:32]);
            push_sched(msg_bits[31:0]);
            for (int j = 0; j < DIGEST_WORDS; j++) begin
                d.word = hash_st[j];
                d.last = (j == DIGEST_WORDS - 1);
                digests_q.push_back(d);
            end
            reset_hash();
        end
    endtask

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    function automatic int unsigned pick_gap();
        return tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic add_beat(input logic [shs_pkg::WORD_W-1:0] word,
                            input logic [shs_pkg::NBYTES_W-1:0] nb,
                            input logic last, input bit hold);
        t_msg_beat b;
        b.word   = word;
        b.nbytes = nb;
        b.last   = last;
        b.gap    = pick_gap();
        b.hold   = hold;
        msg_beats_q.push_back(b);
        beats_loaded++;
    endtask

    task automatic add_message(input int unsigned nwords, input bit hold);
        for (int j = 0; j < nwords; j++) begin
            add_beat($urandom(), 3'($urandom_range(0, 7)), 1'b0, hold && j == 0);
        end
        add_beat($urandom(), 3'($urandom_range(0, 7)), 1'b1, hold && nwords == 0);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    // Monitor: the digest is checked before the message beat of the same edge is predicted.
    always @(posedge i_clk) begin
        t_digest_beat want;
        msg_taken   = 1'b0;
        dig_taken   = 1'b0;
        dig_offered = 1'b0;
        if (i_rst_n) begin
            dig_offered = o_valid;
            if (o_valid && i_ready) begin
                dig_taken = 1'b1;
                if (digests_q.size() == 0) begin
                    flag_error($sformatf("unexpected digest beat word %08h last %0d",
                                         o_digest_word, o_digest_last));
                end else begin
                    want = digests_q.pop_front();
                    if (o_digest_word !== want.word) begin
                        flag_error($sformatf("digest word: expected %08h, got %08h",
                                             want.word, o_digest_word));
                    end
                    if (o_digest_last !== want.last) begin
                        flag_error($sformatf("digest last: expected %0d, got %0d",
                                             want.last, o_digest_last));
                    end
                end
            end
            if (i_valid && o_ready) begin
                msg_taken = 1'b1;
                hash_beat(i_msg_word, i_valid_bytes, i_last);
                beats_accepted++;
            end
        end
    end

    // Message driver.
    always @(negedge i_clk) begin
        logic next_valid;
        next_valid = i_valid;
        if (i_rst_n) begin
            if (msg_taken) begin
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (!staged && msg_beats_q.size() != 0) begin
                    cur_beat = msg_beats_q.pop_front();
                    gap_left = cur_beat.gap;
                    staged   = 1'b1;
                end
                if (staged && !(cur_beat.hold && digests_q.size() != 0)) begin
                    if (gap_left != 0) begin
                        gap_left--;
                    end else begin
                        next_valid = 1'b1;
                        staged     = 1'b0;
                        i_msg_word    <= cur_beat.word;
                        i_valid_bytes <= cur_beat.nbytes;
                        i_last        <= cur_beat.last;
                    end
                end
            end
        end
        i_valid <= next_valid;
    end

    // Digest receiver: each beat waits a drawn number of offered cycles before ready rises.
    always @(negedge i_clk) begin
        if (dig_taken) begin
            if ($urandom_range(0, 15) == 0) begin
                rx_burst = !rx_burst;
            end
            stall_left = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
        end else if (dig_offered && stall_left != 0) begin
            stall_left--;
        end
        i_ready <= (stall_left == 0);
    end

    initial begin
        int unsigned sel;
        int unsigned nwords;
        reset_hash();
        stall_left = $urandom_range(0, MAX_GAP);

        // Directed: empty message with stray bits, short tails, a full final word, oversized counts.
        add_beat(32'hffff_ffff, 3'd0, 1'b1, 1'b0);
        add_beat(32'h6162_6300, 3'd3, 1'b1, 1'b0);
        add_beat(32'hffff_ffff, 3'd1, 1'b1, 1'b0);
        add_beat(32'h0000_0000, 3'd2, 1'b1, 1'b0);
        add_beat(32'hffff_ffff, WHOLE_WORD, 1'b1, 1'b0);
        add_beat(32'h8080_8080, 3'd5, 1'b1, 1'b0);
        add_beat(32'h1234_5678, 3'd6, 1'b1, 1'b0);
        add_beat(32'hffff_ffff, 3'd7, 1'b1, 1'b0);
        // Byte counts on body words are ignored.
        add_beat(32'h0000_0000, 3'd0, 1'b0, 1'b0);
        add_beat(32'hffff_ffff, WHOLE_WORD, 1'b1, 1'b0);
        add_beat(32'hffff_ffff, 3'd7, 1'b0, 1'b0);
        add_beat(32'ha5a5_a5a5, 3'd2, 1'b1, 1'b0);
        add_beat(32'h5a5a_5a5a, 3'd3, 1'b0, 1'b0);
        add_beat(32'h0000_0001, 3'd0, 1'b1, 1'b0);

        // Random messages, weighted towards lengths that push padding into a second block.
        while (beats_loaded < RANDOM_BEATS + 14) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
                nwords = $urandom_range(0, 15);
            end else if (sel < 8) begin
                nwords = $urandom_range(12, 17);
            end else if (sel == 8) begin
                nwords = $urandom_range(28, 33);
            end else begin
                nwords = $urandom_range(0, 3);
            end
            add_message(nwords, beats_loaded == 14 || $urandom_range(0, 9) == 0);
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (beats_accepted == beats_loaded);
        wait (digests_q.size() == 0);
        repeat (SETTLE_TIME) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/shs_pkg.sv
design/shs_ctrl.sv
design/shs_datapath.sv
design/sha256_stream_hasher_core.sv
sim/sha256_stream_hasher_core_tb.sv
